>>> src/life_automaton_grid_core_macros.svh
// Assertion macros shared by the checker of the life grid core.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LIFE_AUTOMATON_GRID_CORE_MACROS_SVH
`define LIFE_AUTOMATON_GRID_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LAG_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("life grid assertion failed");

// Next-cycle implication, disabled during reset
`define LAG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("life grid assertion failed");

`endif

>>> src/lag_pkg.sv
// Shared types and constants of the life grid core.
// No dependencies; imported by the channels, controller and datapath.
package lag_pkg;

   localparam int FUNC_W = 2;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int CFG_W  = 7;

   // Operation selector codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TOGGLE = 2'd0,
      FUNC_STEP   = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   // Row read offsets relative to the sweep pointer
   localparam logic [1:0] OFS_HERE  = 2'd0;
   localparam logic [1:0] OFS_NEXT  = 2'd1;
   localparam logic [1:0] OFS_AFTER = 2'd2;

   // B3/S23 neighbor counts
   localparam logic [3:0] NB_BIRTH   = 4'd3;
   localparam logic [3:0] NB_SURVIVE = 4'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic       cap_req;
      logic       clr_wr;
      logic       rd_req;
      logic [1:0] rd_ofs;
      logic       cell_done;
      logic       step_fill;
      logic       step_load;
      logic       step_wr;
      logic       rsp_load;
   } lag_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              req_oor;
      logic              grid_empty;
      logic              step_last;
      logic              clr_last;
      logic              rsp_free;
   } lag_status_type;

endpackage

>>> src/lag_if.sv
// Valid/ready channels of the life grid core: request and response.
// Depends on lag_pkg for field widths.
interface lag_req_if;
   import lag_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   modport source (output valid, func, row, col, input ready);
   modport sink   (input valid, func, row, col, output ready);
endinterface

interface lag_rsp_if;
   logic valid;
   logic ready;
   logic cell_value;
   logic out_of_range;
   modport source (output valid, cell_value, out_of_range, input ready);
   modport sink   (input valid, cell_value, out_of_range, output ready);
endinterface

>>> src/lag_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lag_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/lag_ctrl.sv
// Controller of the life grid core: sequences clear, cell and step operations.
// Depends on lag_pkg; drives lag_datapath through command and status structs.
module lag_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lag_pkg::lag_status_type status,
   output lag_pkg::lag_cmd_type    cmd
);
   import lag_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CELL,
      ST_FILL,
      ST_LOAD,
      ST_WRITE,
      ST_PUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.func) inside
               FUNC_TOGGLE, FUNC_READ: begin
                  if (status.req_oor) begin
                     state_in = ST_PUT;
                  end else begin
                     cmd.rd_req = 1'b1;
                     state_in   = ST_CELL;
                  end
               end
               FUNC_STEP: begin
                  if (status.grid_empty) begin
                     state_in = ST_PUT;
                  end else begin
                     cmd.rd_ofs = OFS_HERE;
                     state_in   = ST_FILL;
                  end
               end
               default: state_in = ST_PUT;
            endcase
         end
         ST_CELL: begin
            cmd.cell_done = 1'b1;
            state_in      = ST_PUT;
         end
         ST_FILL: begin
            cmd.step_fill = 1'b1;
            cmd.rd_ofs    = OFS_NEXT;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.step_load = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.step_wr = 1'b1;
            cmd.rd_ofs  = OFS_AFTER;
            state_in    = status.step_last ? ST_PUT : ST_LOAD;
         end
         ST_PUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

>>> src/lag_datapath.sv
// Datapath of the life grid core: row-wide grid RAM, three-row window,
// neighbor count logic, request capture and response register.
// Depends on lag_pkg and lag_ram; commanded by lag_ctrl.
module lag_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lag_pkg::lag_cmd_type          cmd,
   output lag_pkg::lag_status_type       status,
   input  logic [lag_pkg::FUNC_W-1:0]    req_func,
   input  logic [lag_pkg::ROW_W-1:0]     req_row,
   input  logic [lag_pkg::COL_W-1:0]     req_col,
   input  logic [lag_pkg::CFG_W-1:0]     grid_rows,
   input  logic [lag_pkg::CFG_W-1:0]     grid_cols,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_cell_value,
   output logic                          rsp_out_of_range
);
   import lag_pkg::*;

   localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PW  = RAW + 1;
   localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CPW = CAW + 1;

   // Captured request
   logic [FUNC_W-1:0] func_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic              res_cell_ff;

   // Sweep pointer (clear pass and step)
   logic [PW-1:0] ptr_ff;

   // Three-row window, raw stored contents
   logic [MAX_COLS-1:0] above_ff, center_ff, below_ff;

   // Response register
   logic rsp_valid_ff, rsp_cell_ff, rsp_oor_ff;

   logic [PW-1:0]       rows_used;
   logic [CPW-1:0]      cols_used;
   logic                is_toggle, is_cell_op, req_oor, below_ok;
   logic [RAW-1:0]      row_addr, rd_addr, wr_addr;
   logic [CAW-1:0]      col_idx;
   logic [MAX_COLS-1:0] col_mask, flip, rd_data, wr_data;
   logic                wr_en;
   logic [MAX_COLS-1:0] am, cm, bm, aw, ae, cw, ce, bw, be;
   logic [MAX_COLS-1:0] life_row, step_row;
   logic [3:0]          nb_cnt;

   // Grid size in use, clipped to storage
   assign rows_used = (32'(grid_rows) >= 32'(MAX_ROWS)) ? PW'(MAX_ROWS) : PW'(grid_rows);
   assign cols_used = (32'(grid_cols) >= 32'(MAX_COLS)) ? CPW'(MAX_COLS) : CPW'(grid_cols);

   assign is_toggle  = (func_ff == FUNC_TOGGLE);
   assign is_cell_op = (func_ff == FUNC_TOGGLE) || (func_ff == FUNC_READ);
   assign req_oor    = (32'(row_ff) >= 32'(rows_used)) || (32'(col_ff) >= 32'(cols_used));
   assign below_ok   = (32'(ptr_ff) + 32'd1) < 32'(rows_used);

   assign row_addr = RAW'(row_ff);
   assign col_idx  = CAW'(col_ff);

   // Column mask and single-bit flip vector
   always_comb begin
      flip = '0;
      flip[col_idx] = 1'b1;
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = (32'(c) < 32'(cols_used));
      end
   end

   // Neighbor rows shifted west and east; columns outside the grid read dead
   assign am = above_ff & col_mask;
   assign cm = center_ff & col_mask;
   assign bm = below_ff & col_mask;
   assign aw = am << 1;
   assign ae = am >> 1;
   assign cw = cm << 1;
   assign ce = cm >> 1;
   assign bw = bm << 1;
   assign be = bm >> 1;

   // Next generation of the center row, one counter per column
   always_comb begin
      nb_cnt = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         nb_cnt = 4'(aw[c]) + 4'(am[c]) + 4'(ae[c]) + 4'(cw[c]) +
                  4'(ce[c]) + 4'(bw[c]) + 4'(bm[c]) + 4'(be[c]);
         life_row[c] = (nb_cnt == NB_BIRTH) || (cm[c] && (nb_cnt == NB_SURVIVE));
      end
   end

   // Columns outside the grid keep their stored value
   assign step_row = (life_row & col_mask) | (center_ff & ~col_mask);

   // RAM ports
   assign rd_addr = cmd.rd_req ? row_addr : RAW'(ptr_ff + PW'(cmd.rd_ofs));

   always_comb begin
      wr_en   = cmd.clr_wr || cmd.step_wr || (cmd.cell_done && is_toggle);
      wr_addr = cmd.cell_done ? row_addr : RAW'(ptr_ff);
      if (cmd.clr_wr) begin
         wr_data = '0;
      end else if (cmd.cell_done) begin
         wr_data = rd_data ^ flip;
      end else begin
         wr_data = step_row;
      end
   end

   lag_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cap_req) begin
            ptr_ff <= '0;
         end else if (cmd.clr_wr || cmd.step_wr) begin
            ptr_ff <= ptr_ff + PW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         func_ff     <= req_func;
         row_ff      <= req_row;
         col_ff      <= req_col;
         res_cell_ff <= 1'b0;
         above_ff    <= '0;
      end else if (cmd.cell_done) begin
         res_cell_ff <= rd_data[col_idx] ^ is_toggle;
      end
      if (cmd.step_fill) begin
         center_ff <= rd_data;
      end
      if (cmd.step_load) begin
         below_ff <= below_ok ? rd_data : '0;
      end
      if (cmd.step_wr) begin
         above_ff  <= center_ff;
         center_ff <= below_ff;
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= res_cell_ff;
         rsp_oor_ff  <= is_cell_op && req_oor;
      end
   end

   // Status to the controller
   assign status.func       = func_ff;
   assign status.req_oor    = req_oor;
   assign status.grid_empty = (rows_used == '0) || (cols_used == '0);
   assign status.step_last  = !below_ok;
   assign status.clr_last   = (32'(ptr_ff) == 32'(MAX_ROWS - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_value   = rsp_cell_ff;
   assign rsp_out_of_range = rsp_oor_ff;
endmodule

>>> src/life_automaton_grid_core.sv
// Life grid core top level: configuration registers, controller and datapath.
// Depends on lag_pkg, lag_if, lag_ctrl, lag_datapath and lag_ram.
//
// Conway B3/S23 grid of one-bit cells held one row per word in a single RAM
// (MAX_ROWS words of MAX_COLS bits). After reset a clearing pass writes every
// row dead with req_ch.ready low; CSR writes are taken during it. One
// transaction is worked at a time. Toggle and read go through decode, row
// read and update; an off-grid coordinate, an unused code or a step on an
// empty grid goes straight from decode to the response. In a step the sweep
// reads one row ahead through the RAM's read port and writes the updated row
// back, with the row above and the current row held in registers so every
// new value comes from the old grid. The response sits in an output
// register; a new transaction is accepted while it waits, and the next
// response waits for it to drain. Registers: grid_rows at 0x0, grid_cols at
// 0x4, both resetting to 10; sizes above MAX_ROWS or MAX_COLS are clipped.
module life_automaton_grid_core #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   lag_req_if.sink     req_ch,
   lag_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lag_pkg::*;

   localparam logic             REG_GRID_ROWS = 1'b0;
   localparam logic             REG_GRID_COLS = 1'b1;
   localparam logic [CFG_W-1:0] SIZE_RESET    = 7'd10;

   logic [CFG_W-1:0] grid_rows_ff, grid_cols_ff;
   logic             csr_write;
   logic             csr_index;
   lag_cmd_type      cmd;
   lag_status_type   status;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= SIZE_RESET;
         grid_cols_ff <= SIZE_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_GRID_ROWS) begin
            grid_rows_ff <= csr_pwdata[CFG_W-1:0];
         end
         if (csr_index == REG_GRID_COLS) begin
            grid_cols_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_index == REG_GRID_COLS) ? 32'(grid_cols_ff) : 32'(grid_rows_ff);

   lag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lag_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_ch.func),
      .req_row          (req_ch.row),
      .req_col          (req_ch.col),
      .grid_rows        (grid_rows_ff),
      .grid_cols        (grid_cols_ff),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_cell_value   (rsp_ch.cell_value),
      .rsp_out_of_range (rsp_ch.out_of_range)
   );
endmodule

>>> src/lag_checker.sv
// Port-level checker of the life grid core, bound to the top level.
// Depends on life_automaton_grid_core_macros.svh.
`include "life_automaton_grid_core_macros.svh"

module lag_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_cell_value,
   input logic rsp_out_of_range
);
   // Out-of-range responses never report a live cell
   `LAG_ASSERT_NOW(a_oor_dead, clock, reset, rsp_valid, !(rsp_cell_value && rsp_out_of_range))

   // Clearing pass blocks requests right after reset
   `LAG_ASSERT_NOW(a_clear_blocks, clock, reset, $fell(reset), !req_ready)

   // One transaction at a time: ready drops after an acceptance
   `LAG_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // Stalled response holds
   `LAG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_cell_value) && $stable(rsp_out_of_range))
endmodule

bind life_automaton_grid_core lag_checker u_lag_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_cell_value   (rsp_ch.cell_value),
   .rsp_out_of_range (rsp_ch.out_of_range)
);
